// ===== hdl/bam_pkg.sv =====
// ============================================================================
// bam_pkg
// Shared types, constants and helpers of the binary-angle sine, cosine and
// tangent unit.
// ============================================================================
`default_nettype none

package bam_pkg;

  // Function select codes carried in the input tuser.
  localparam logic [1:0] OP_SIN    = 2'd0;
  localparam logic [1:0] OP_COS    = 2'd1;
  localparam logic [1:0] OP_TAN    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Q30 constants, the binary-angle quarter turn and the 16.16 result limits.
  localparam logic [31:0] Q30_UNIT       = 32'h4000_0000;
  localparam logic [30:0] Q30_QUADRANT_RAD = 31'd1686629713;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
  localparam logic [31:0] POS_LIMIT      = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT      = 32'h8000_0000;

  // Horner divisors 156, 110, 72, 42, 20, 6 as exact reciprocal multiplies:
  // floor(x / d) == (x * ceil(2^k / d)) >> k for every 32-bit x, with
  // k = 32 + ceil(log2(d)).
  localparam int DIV_N = 6;
  localparam int DIV_SHIFT [DIV_N] = '{40, 39, 39, 38, 37, 35};
  localparam logic [33:0] DIV_MAGIC [DIV_N] = '{
    34'(((64'd1 << 40) + 64'd155) / 64'd156),
    34'(((64'd1 << 39) + 64'd109) / 64'd110),
    34'(((64'd1 << 39) + 64'd71) / 64'd72),
    34'(((64'd1 << 38) + 64'd41) / 64'd42),
    34'(((64'd1 << 37) + 64'd19) / 64'd20),
    34'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  // Pipeline depths in advancing cycles, and the queue depth in entries.
  localparam int POLY_LAT   = 29;
  localparam int DIV_LAT    = 33;
  localparam int FIFO_DEPTH = 4;

  // One classified item between front and back.
  typedef struct packed {
    logic [1:0]  op;
    logic        s_lo;   // sine angle lies in the lower half turn
    logic        c_lo;   // cosine angle lies in the lower half turn
    logic [30:0] ts;     // mirrored Q30 position for the sine
    logic [30:0] tc;     // mirrored Q30 position for the cosine
  } bam_item_t;

  // Control carried beside the polynomial lanes.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       s_lo;
    logic       c_lo;
  } bam_meta_t;

  // Control and finished sine or cosine carried beside the divider.
  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic [31:0] fix;    // rounded 16.16 sine or cosine
    logic        pole;   // cosine magnitude is zero
    logic        ovf;    // quotient reaches 2^32
    logic        sneg;   // sine is negative
    logic        tneg;   // quotient is negative
  } bam_late_t;

  // Q30 multiply rounding: (x + 2^29) >> 30.
  function automatic logic [35:0] q30_round(input logic [65:0] x);
    logic [66:0] s;
    s = {1'b0, x} + 67'(64'd1 << 29);
    return s[66:30] > 37'h0 ? s[65:30] : 36'h0;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bam_sine_cosine_tangent_unit.sv =====
// ============================================================================
// bam_sine_cosine_tangent_unit
// Sine, cosine and tangent of a 32-bit binary angle, signed 16.16 results.
// ============================================================================
//
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: angle[31:0]; tuser: opcode[1:0]
// m_axis    out  tdata: result[31:0]
//
// One beat is taken every cycle unless the front holds a beat while the queue
// is full; every back stage is a register, and the back advances together.
// A beat passes the front register, the queue, the Horner lanes, the
// one-bit-per-stage tangent divider and the output register.
// Reset clears only the valid flags, control pipes, queue pointers and count.
// A stall on m_axis freezes the back; the queue and front keep filling.
`default_nettype none

module bam_sine_cosine_tangent_unit
  import bam_pkg::*;
#(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // angle[31:0]
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // result[31:0]
);

  logic      push, full, pop, empty, adv;
  bam_item_t fr_item, q_item;
  bam_meta_t meta_q [POLY_LAT];
  bam_late_t late_q [DIV_LAT];
  bam_late_t late_d;
  logic [30:0] sm, cm, fm;
  logic [31:0] quo;
  logic        sneg, cneg, fneg;
  logic [31:0] rnd;
  logic        out_valid_q;
  logic [31:0] out_data_q, out_data_d;
  logic        qn;

  // Front and queue.
  bam_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .angle_i (s_axis_tdata),
    .op_i    (s_axis_tuser),
    .full_i  (full),
    .push_o  (push),
    .item_o  (fr_item)
  );

  bam_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_item),
    .empty_o (empty)
  );

  // The back moves as one when the output slot is free or being taken.
  assign adv = !out_valid_q || m_axis_tready;
  assign pop = adv && !empty;

  // Sine and cosine lanes.
  bam_poly u_sin (.clk_i(clk_i), .en_i(adv), .t_i(q_item.ts), .mag_o(sm));
  bam_poly u_cos (.clk_i(clk_i), .en_i(adv), .t_i(q_item.tc), .mag_o(cm));

  // Control beside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q[0] <= '0;
    end else if (adv) begin
      meta_q[0] <= '{valid: pop, op: q_item.op, s_lo: q_item.s_lo, c_lo: q_item.c_lo};
    end
  end

  for (genvar k = 1; k < POLY_LAT; k++) begin : g_meta
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (adv) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // Signs, 16.16 rounding and tangent special cases.
  always_comb begin
    sneg = meta_q[POLY_LAT-1].s_lo && (sm != '0);
    cneg = meta_q[POLY_LAT-1].c_lo && (cm != '0);
    fm   = (meta_q[POLY_LAT-1].op == OP_COS) ? cm : sm;
    fneg = (meta_q[POLY_LAT-1].op == OP_COS) ? cneg : sneg;
    rnd  = ({1'b0, fm} + 32'h0000_2000) >> 14;
    late_d.valid = meta_q[POLY_LAT-1].valid;
    late_d.op    = meta_q[POLY_LAT-1].op;
    late_d.fix   = fneg ? (32'h0 - rnd) : rnd;
    late_d.pole  = (cm == '0);
    late_d.ovf   = {16'b0, sm[30:16]} >= cm;
    late_d.sneg  = sneg;
    late_d.tneg  = sneg ^ cneg;
  end

  bam_tdiv u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({sm, 16'b0}),
    .den_i (cm),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      late_q[0] <= '0;
    end else if (adv) begin
      late_q[0] <= late_d;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_late
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        late_q[k] <= '0;
      end else if (adv) begin
        late_q[k] <= late_q[k-1];
      end
    end
  end

  // Result select, tangent saturation and zero for the unused opcode.
  always_comb begin
    qn = late_q[DIV_LAT-1].tneg && (quo != '0);
    unique case (late_q[DIV_LAT-1].op)
      OP_SIN, OP_COS: out_data_d = late_q[DIV_LAT-1].fix;
      OP_TAN: begin
        if (late_q[DIV_LAT-1].pole) begin
          out_data_d = late_q[DIV_LAT-1].sneg ? NEG_LIMIT : POS_LIMIT;
        end else if (late_q[DIV_LAT-1].ovf) begin
          out_data_d = late_q[DIV_LAT-1].tneg ? NEG_LIMIT : POS_LIMIT;
        end else if (qn) begin
          out_data_d = (quo > NEG_LIMIT) ? NEG_LIMIT : (32'h0 - quo);
        end else begin
          out_data_d = (quo > POS_LIMIT) ? POS_LIMIT : quo;
        end
      end
      default: out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= late_q[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A sine or cosine never leaves the range of two.
  a_trig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    late_q[DIV_LAT-1].valid &&
    (late_q[DIV_LAT-1].op == OP_SIN || late_q[DIV_LAT-1].op == OP_COS)
    |-> ($signed(late_q[DIV_LAT-1].fix) < 32'sd131072 &&
         $signed(late_q[DIV_LAT-1].fix) > -32'sd131072))
    else $error("sine or cosine out of range");

  // A tangent pole leaves as one of the two limits.
  a_pole_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && late_q[DIV_LAT-1].valid && late_q[DIV_LAT-1].op == OP_TAN &&
    late_q[DIV_LAT-1].pole
    |=> (m_axis_tdata == POS_LIMIT || m_axis_tdata == NEG_LIMIT))
    else $error("tangent pole not saturated");

  // A negative sine or cosine that rounds to a nonzero value carries a set
  // sign bit.
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[POLY_LAT-1].valid && fneg && (rnd != '0) |-> late_d.fix[31])
    else $error("sign lost in rounding");

endmodule

`default_nettype wire

// ===== hdl/bam_fifo.sv =====
// ============================================================================
// bam_fifo
// Short register queue that decouples the classifying front from the
// arithmetic back.
// ============================================================================
`default_nettype none

module bam_fifo
  import bam_pkg::*;
#(
  parameter int Depth = FIFO_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  bam_item_t      data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output bam_item_t      data_o,
  output logic           empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  bam_item_t       mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);

  // The queue is never written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/bam_front.sv =====
// ============================================================================
// bam_front
// Input stage: accepts beats, folds the angle into quadrant flags and
// mirrored Q30 positions for sine and cosine, and feeds the queue.
// ============================================================================
`default_nettype none

module bam_front
  import bam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [31:0] angle_i,
  input  wire logic [1:0]  op_i,
  input  wire logic        full_i,
  output logic             push_o,
  output bam_item_t        item_o
);

  logic      fr_valid_q;
  bam_item_t fr_item_q, fr_item_d;
  logic [31:0] ca;

  // Classify: quadrant sign flags and mirrored positions.
  always_comb begin
    ca            = angle_i + QUARTER_TURN;
    fr_item_d.op  = op_i;
    fr_item_d.s_lo = angle_i[31];
    fr_item_d.c_lo = ca[31];
    fr_item_d.ts  = angle_i[30] ? 31'(Q30_UNIT) - {1'b0, angle_i[29:0]}
                                : {1'b0, angle_i[29:0]};
    fr_item_d.tc  = ca[30] ? 31'(Q30_UNIT) - {1'b0, ca[29:0]}
                           : {1'b0, ca[29:0]};
  end

  assign push_o  = fr_valid_q && !full_i;
  assign ready_o = !fr_valid_q || !full_i;
  assign item_o  = fr_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      fr_valid_q <= 1'b1;
    end else if (push_o) begin
      fr_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      fr_item_q <= fr_item_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bam_poly.sv =====
// ============================================================================
// bam_poly
// Pipelined Q30 Horner evaluation of sin(t*pi/2) for t in [0, 1.0].
// ============================================================================
`default_nettype none

module bam_poly
  import bam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [30:0] t_i,
  output logic [30:0]      mag_o
);

  typedef struct packed {
    logic [30:0] y;
    logic [31:0] y2;
  } yy_t;

  localparam int KV_N = 23;

  logic [30:0] t_q, y_q, y4_q;
  logic [61:0] m1_q, m2_q, mf_q;
  logic [65:0] d0_q;
  logic [30:0] mag_q;
  yy_t         kv_q [KV_N];
  logic [62:0] hm_q [DIV_N];
  logic [31:0] hx_q [DIV_N];
  logic [65:0] hd_q [DIV_N];
  logic [30:0] p_q  [DIV_N];
  logic [35:0] r1, r2, rf;
  logic [65:0] sh0;

  assign r1  = q30_round({4'b0, m1_q});
  assign r2  = q30_round({4'b0, m2_q});
  assign rf  = q30_round({4'b0, mf_q});
  assign sh0 = d0_q >> DIV_SHIFT[0];

  // Angle scaling, squaring, the first Horner term and the final multiply by y.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_i;
      m1_q     <= 62'(t_q) * 62'(Q30_QUADRANT_RAD);
      y_q      <= r1[30:0];
      m2_q     <= 62'(y_q) * 62'(y_q);
      y4_q     <= y_q;
      kv_q[0]  <= '{y: y4_q, y2: r2[31:0]};
      d0_q     <= 66'(kv_q[0].y2) * 66'(DIV_MAGIC[0]);
      p_q[0]   <= 31'(Q30_UNIT - sh0[31:0]);
      mf_q     <= 62'(kv_q[KV_N-1].y) * 62'(p_q[DIV_N-1]);
      mag_q    <= rf[30:0];
    end
  end

  // Carry y and y^2 down the pipe.
  for (genvar k = 1; k < KV_N; k++) begin : g_kv
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kv_q[k] <= kv_q[k-1];
      end
    end
  end

  // Remaining Horner steps: multiply, round, reciprocal multiply, subtract.
  for (genvar j = 1; j < DIV_N; j++) begin : g_step
    logic [35:0] hr;
    logic [65:0] hs;
    assign hr = q30_round({3'b0, hm_q[j]});
    assign hs = hd_q[j] >> DIV_SHIFT[j];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hm_q[j] <= 63'(kv_q[2 + 4 * (j - 1)].y2) * 63'(p_q[j-1]);
        hx_q[j] <= hr[31:0];
        hd_q[j] <= 66'(hx_q[j]) * 66'(DIV_MAGIC[j]);
        p_q[j]  <= 31'(Q30_UNIT - hs[31:0]);
      end
    end
  end

  // Slot zero of hm_q, hx_q and hd_q is unused by the loop.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hm_q[0] <= '0;
      hx_q[0] <= hm_q[0][31:0];
      hd_q[0] <= {34'b0, hx_q[0]};
    end
  end

  assign mag_o = mag_q ^ {31{hd_q[0][0] & 1'b0}};

endmodule

`default_nettype wire

// ===== hdl/bam_tdiv.sv =====
// ============================================================================
// bam_tdiv
// Pipelined restoring divider, one quotient bit per stage, giving
// (sine << 16) / cosine when the quotient is below 2^32.
// ============================================================================
`default_nettype none

module bam_tdiv
  import bam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [46:0] num_i,
  input  wire logic [30:0] den_i,
  output logic [31:0]      quo_o
);

  logic [31:0] n_q [DIV_LAT];
  logic [30:0] d_q [DIV_LAT];
  logic [30:0] r_q [DIV_LAT];
  logic [31:0] q_q [DIV_LAT];

  // Load: the high numerator bits start the remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= num_i[31:0];
      d_q[0] <= den_i;
      r_q[0] <= {16'b0, num_i[46:32]};
      q_q[0] <= '0;
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_bit
    logic [31:0] rs;
    logic [31:0] rd;
    logic        ge;
    assign rs = {r_q[k-1], n_q[k-1][DIV_LAT-1-k]};
    assign ge = rs >= {1'b0, d_q[k-1]};
    assign rd = rs - {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_q[k-1];
        d_q[k] <= d_q[k-1];
        r_q[k] <= ge ? rd[30:0] : rs[30:0];
        q_q[k] <= {q_q[k-1][30:0], ge};
      end
    end
  end

  assign quo_o = q_q[DIV_LAT-1];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ============================================================================
// testbench
// Checks the binary-angle sine, cosine and tangent unit against a built-in
// fixed-point predictor, with directed corner angles and random traffic.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module testbench
  import bam_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // angle[31:0]
  logic [1:0]  s_axis_tuser = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // result[31:0]

  logic [31:0] expected_results[$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bam_sine_cosine_tangent_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Q30 multiply with round to nearest; all operands are non-negative.
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Seven-term Horner series of sin(t*pi/2) within one quadrant.
  function automatic longint unsigned quadrant_sin(longint unsigned t);
    longint unsigned y, y2, p;
    y  = q30_mul(t, 64'd1686629713);
    y2 = q30_mul(y, y);
    p  = 64'd1073741824 - q30_mul(y2, 64'd1073741824) / 156;
    p  = 64'd1073741824 - q30_mul(y2, p) / 110;
    p  = 64'd1073741824 - q30_mul(y2, p) / 72;
    p  = 64'd1073741824 - q30_mul(y2, p) / 42;
    p  = 64'd1073741824 - q30_mul(y2, p) / 20;
    p  = 64'd1073741824 - q30_mul(y2, p) / 6;
    return q30_mul(y, p);
  endfunction

  // Signed Q30 sine of a binary angle as magnitude and sign.
  function automatic void bam_sin(input logic [31:0] a, output longint unsigned mag,
                                  output bit neg);
    longint unsigned t;
    t = {34'd0, a[29:0]};
    if (a[30]) t = 64'd1073741824 - t;
    mag = quadrant_sin(t);
    neg = a[31] && (mag != 0);
  endfunction

  function automatic logic [31:0] to_fix16(longint unsigned mag, bit neg);
    logic [31:0] m;
    m = 32'((mag + (64'd1 << 13)) >> 14);
    return neg ? -m : m;
  endfunction

  // Expected 16.16 result of one opcode on one angle.
  function automatic logic [31:0] trig_value(logic [31:0] a, logic [1:0] op);
    longint unsigned sm, cm, q;
    bit sn, cn;
    bam_sin(a, sm, sn);
    bam_sin(a + QUARTER_TURN, cm, cn);
    case (op)
      OP_SIN: return to_fix16(sm, sn);
      OP_COS: return to_fix16(cm, cn);
      OP_TAN: begin
        if (cm == 0) return sn ? NEG_LIMIT : POS_LIMIT;
        q = (sm << 16) / cm;
        if ((sn != cn) && (q != 0)) begin
          if (q > 64'h8000_0000) return NEG_LIMIT;
          return -(32'(q));
        end
        if (q > 64'h7FFF_FFFF) return POS_LIMIT;
        return 32'(q);
      end
      default: return 32'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Send one beat, idling beforehand at the current rate.
  task automatic send_angle(input logic [31:0] a, input logic [1:0] op);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(trig_value(a, op));
  endtask

  // Receiver backpressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
      end else begin
        logic [31:0] want;
        want = expected_results.pop_front();
        if (m_axis_tdata !== want) report_mismatch("result", m_axis_tdata, want);
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Quadrant boundaries, poles, extremes of the angle, every opcode.
  task automatic test_directed();
    logic [31:0] angles[8] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                               32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'h2000_0000,
                               32'h4000_0001};
    foreach (angles[i])
      for (int op = 0; op < 3; op++) send_angle(angles[i], 2'(op));
    send_angle(32'h1234_5678, OP_UNUSED);  // unused opcode gives zero
  endtask

  // Random angles and opcodes, biased toward quadrant edges, which hold the tangent poles.
  task automatic test_random(input int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      a = $urandom();
      if ($urandom_range(3) == 0) a = {a[31:30], 30'h0} + 32'($urandom_range(64)) - 32;
      send_angle(a, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 25; receiver_idle_pct = 67;
    test_directed();
    test_random(160);
    wait_drained();  // sender holds off until every result is back
    sender_idle_pct = 67; receiver_idle_pct = 25;
    test_random(160);
    sender_idle_pct = 0; receiver_idle_pct = 0;
    test_random(160);
    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d results: sine, cosine, tangent and unused opcode,", result_count);
    $display("quadrant edges, poles and three idling profiles.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
